>>> src/mbb_pkg.sv
// shared types and codes of the masked blend blit
`default_nettype none

package mbb_pkg;

	// pixel word width, three 8-bit channels with channel 0 in the low byte
	localparam int PIX_W = 24;

	// command opcodes
	localparam logic [1:0] OP_PIXEL   = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// skip causes
	localparam logic [1:0] SKIP_NONE     = 2'd0;
	localparam logic [1:0] SKIP_MASKED   = 2'd1;
	localparam logic [1:0] SKIP_CLIPPED  = 2'd2;
	localparam logic [1:0] SKIP_PAST_END = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_SPRITE_WIDTH  = 3'd2;
	localparam logic [2:0] CFG_SPRITE_HEIGHT = 3'd3;
	localparam logic [2:0] CFG_ORIGIN_COLUMN = 3'd4;
	localparam logic [2:0] CFG_ORIGIN_ROW    = 3'd5;
	localparam logic [2:0] CFG_BLEND_MODE    = 3'd6;

	// command word
	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] src_channel0;
		logic [7:0] src_channel1;
		logic [7:0] src_channel2;
		logic       src_visible;
		logic [5:0] read_column;
		logic [5:0] read_row;
	} mbb_in_t;

	// result word
	typedef struct packed {
		logic [7:0] out_channel0;
		logic [7:0] out_channel1;
		logic [7:0] out_channel2;
		logic       did_write;
		logic [1:0] skip_cause;
	} mbb_out_t;

	// configuration registers, origins are two's complement
	typedef struct packed {
		logic [6:0] screen_width;
		logic [6:0] screen_height;
		logic [6:0] sprite_width;
		logic [6:0] sprite_height;
		logic [7:0] origin_column;
		logic [7:0] origin_row;
		logic       blend_mode;
	} mbb_cfg_t;

	// access decision for one command word
	typedef struct packed {
		logic       write_en;
		logic       read_en;
		logic [1:0] cause;
	} mbb_loc_t;

endpackage

`default_nettype wire

>>> src/mbb_frame_ram.sv
// frame store: one write port, one read port with registered read data
`default_nettype none

module mbb_frame_ram #(
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [mbb_pkg::PIX_W-1:0] wdata,
	input  wire logic                     re,
	input  wire logic [AW-1:0]            raddr,
	output logic      [mbb_pkg::PIX_W-1:0] rdata
);

	logic [mbb_pkg::PIX_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/mbb_locate.sv
// scan position, clipping and frame address for each command word
`default_nettype none

module mbb_locate #(
	parameter int MAX_DIMENSION = 64,
	parameter int FRAME_PIXELS = 4096,
	localparam int AW = $clog2(FRAME_PIXELS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire mbb_pkg::mbb_in_t  cmd,
	input  wire mbb_pkg::mbb_cfg_t cfg,
	output mbb_pkg::mbb_loc_t      loc,
	output logic [AW-1:0]          addr
);

	localparam int DimCap = (MAX_DIMENSION > 127) ? 127 : MAX_DIMENSION;
	localparam int IW = (AW + 1 > 15) ? AW + 1 : 15;

	logic [6:0]        sw, sh, spw, sph;
	logic [6:0]        scan_col_q, scan_row_q;
	logic [7:0]        col_inc;
	logic signed [9:0] dc, dr;
	logic              past_end, pix_in_screen, rd_in_screen, idx_ok;
	logic [6:0]        col_sel, row_sel;
	logic [13:0]       prod;
	logic [IW-1:0]     idx;

	// clamp dimensions
	assign sw  = (cfg.screen_width  > 7'(DimCap)) ? 7'(DimCap) : cfg.screen_width;
	assign sh  = (cfg.screen_height > 7'(DimCap)) ? 7'(DimCap) : cfg.screen_height;
	assign spw = (cfg.sprite_width  > 7'(DimCap)) ? 7'(DimCap) : cfg.sprite_width;
	assign sph = (cfg.sprite_height > 7'(DimCap)) ? 7'(DimCap) : cfg.sprite_height;

	// destination position of the current sprite pixel
	assign dc = $signed({{2{cfg.origin_column[7]}}, cfg.origin_column})
		+ $signed({3'b000, scan_col_q});
	assign dr = $signed({{2{cfg.origin_row[7]}}, cfg.origin_row})
		+ $signed({3'b000, scan_row_q});

	assign past_end = (spw == 7'd0) || (scan_row_q >= sph);
	assign pix_in_screen = !dc[9] && !dr[9]
		&& (dc[8:0] < {2'b00, sw}) && (dr[8:0] < {2'b00, sh});
	assign rd_in_screen = ({1'b0, cmd.read_column} < sw) && ({1'b0, cmd.read_row} < sh);

	// one shared row times width product
	assign col_sel = (cmd.opcode == mbb_pkg::OP_PIXEL) ? dc[6:0] : {1'b0, cmd.read_column};
	assign row_sel = (cmd.opcode == mbb_pkg::OP_PIXEL) ? dr[6:0] : {1'b0, cmd.read_row};
	assign prod    = row_sel * sw;
	assign idx     = IW'(col_sel) + IW'(prod);
	assign idx_ok  = idx < IW'(FRAME_PIXELS);
	assign addr    = idx[AW-1:0];

	// access decision and skip cause
	always_comb begin
		loc = '0;
		case (cmd.opcode)
			mbb_pkg::OP_PIXEL: begin
				if (past_end) begin
					loc.cause = mbb_pkg::SKIP_PAST_END;
				end else if (!cmd.src_visible) begin
					loc.cause = mbb_pkg::SKIP_MASKED;
				end else if (!(pix_in_screen && idx_ok)) begin
					loc.cause = mbb_pkg::SKIP_CLIPPED;
				end else begin
					loc.write_en = 1'b1;
				end
			end
			mbb_pkg::OP_READ: begin
				if (rd_in_screen && idx_ok) begin
					loc.read_en = 1'b1;
				end else begin
					loc.cause = mbb_pkg::SKIP_CLIPPED;
				end
			end
			default: begin
				loc = '0;
			end
		endcase
	end

	assign col_inc = {1'b0, scan_col_q} + 8'd1;

	// scan position, wraps at the sprite width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_col_q <= '0;
			scan_row_q <= '0;
		end else if (take) begin
			case (cmd.opcode)
				mbb_pkg::OP_PIXEL: begin
					if (!past_end) begin
						if (col_inc >= {1'b0, spw}) begin
							scan_col_q <= '0;
							scan_row_q <= scan_row_q + 7'd1;
						end else begin
							scan_col_q <= col_inc[6:0];
						end
					end
				end
				mbb_pkg::OP_RESTART: begin
					scan_col_q <= '0;
					scan_row_q <= '0;
				end
				default: begin
					scan_col_q <= scan_col_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/mbb_tint.sv
// one channel of the tint blend: floor((d*(255-c) + c*c) / 255)
`default_nettype none

module mbb_tint (
	input  wire logic [7:0] d,
	input  wire logic [7:0] c,
	output logic      [7:0] v
);

	logic [15:0] keep_p, tint_p;
	logic [16:0] num, quo;

	assign keep_p = d * (8'd255 - c);
	assign tint_p = c * c;
	assign num    = 17'(keep_p) + 17'(tint_p);

	// exact divide by 255 for a quotient up to 255
	assign quo = (num + (num >> 8) + 17'd1) >> 8;
	assign v   = quo[7:0];

endmodule

`default_nettype wire

>>> src/masked_blend_blit.sv
// Masked sprite blit with clipping and tint blend into a frame store.
//
// Command words arrive on cmd (valid/ready): a sprite pixel in raster order,
// a frame pixel read, or a scan restart. Each word gives exactly one result
// word on res (valid/ready), in order. Registers are written on the cfg
// channel (index, data), which is always ready; write them only while idle.
//
// Pipeline: the word is located and the frame read is issued on acceptance,
// the blend stage then blends and writes back; the result register shows it.
// res_valid rises when the word moves from the blend stage into the result
// register; while res_ready is high, one word per cycle is sustained,
// set by the single read-modify-write pass through the frame RAM.
// A write in flight is forwarded to a read of the same pixel one word later.
//
// After reset all FRAME_PIXELS addresses (4096 by default) of the frame RAM
// are zeroed one pixel a cycle; cmd_ready stays low until that is done. When
// res_ready is low, the result register holds, one more word can enter the
// blend stage, and then cmd_ready drops until the result is taken.
`default_nettype none

module masked_blend_blit #(
	parameter int MAX_DIMENSION = 64,
	parameter int FRAME_PIXELS = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire mbb_pkg::mbb_in_t  cmd,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output mbb_pkg::mbb_out_t      res,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [7:0]        cfg_data
);

	localparam int AW = $clog2(FRAME_PIXELS);

	mbb_pkg::mbb_cfg_t cfg_q;
	mbb_pkg::mbb_loc_t loc;
	logic [AW-1:0]     loc_addr;

	logic              accept, s1_adv, item_we, ram_we;
	logic              clearing_q;
	logic [AW-1:0]     clr_addr_q, ram_waddr;
	logic [mbb_pkg::PIX_W-1:0] ram_wdata, rd_data, old_px, new_px;

	logic              valid_s1, write_s1, read_s1, fwd_hit_s1;
	logic [1:0]        cause_s1;
	logic [AW-1:0]     addr_s1;
	logic [7:0]        src_s1 [3];
	logic [mbb_pkg::PIX_W-1:0] fwd_data_s1;

	logic [7:0]        old_ch [3];
	logic [7:0]        tint_ch [3];
	logic [7:0]        new_ch [3];

	logic              res_valid_q;
	mbb_pkg::mbb_out_t res_q;

	assign cfg_ready = 1'b1;
	assign accept    = cmd_valid && cmd_ready;
	assign s1_adv    = !res_valid_q || res_ready;
	assign cmd_ready = !clearing_q && (!valid_s1 || s1_adv);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= 7'd64;
			cfg_q.screen_height <= 7'd64;
			cfg_q.sprite_width  <= 7'd64;
			cfg_q.sprite_height <= 7'd64;
			cfg_q.origin_column <= '0;
			cfg_q.origin_row    <= '0;
			cfg_q.blend_mode    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mbb_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[6:0];
				mbb_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[6:0];
				mbb_pkg::CFG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data[6:0];
				mbb_pkg::CFG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_data[6:0];
				mbb_pkg::CFG_ORIGIN_COLUMN: cfg_q.origin_column <= cfg_data;
				mbb_pkg::CFG_ORIGIN_ROW:    cfg_q.origin_row    <= cfg_data;
				mbb_pkg::CFG_BLEND_MODE:    cfg_q.blend_mode    <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// scan position and address
	mbb_locate #(
		.MAX_DIMENSION(MAX_DIMENSION),
		.FRAME_PIXELS (FRAME_PIXELS)
	) u_locate (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (accept),
		.cmd   (cmd),
		.cfg   (cfg_q),
		.loc   (loc),
		.addr  (loc_addr)
	);

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(FRAME_PIXELS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// write port shared by the clearing pass and the blend stage
	assign item_we   = valid_s1 && write_s1 && s1_adv;
	assign ram_we    = clearing_q || item_we;
	assign ram_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : new_px;

	mbb_frame_ram #(
		.DEPTH(FRAME_PIXELS)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(loc_addr),
		.rdata(rd_data)
	);

	// blend stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1   <= 1'b1;
			fwd_hit_s1 <= item_we && (addr_s1 == loc_addr);
		end else if (s1_adv) begin
			valid_s1   <= 1'b0;
		end
	end

	// blend stage payload, forward data captured with the read
	always_ff @(posedge clk) begin
		if (accept) begin
			write_s1    <= loc.write_en;
			read_s1     <= loc.read_en;
			cause_s1    <= loc.cause;
			addr_s1     <= loc_addr;
			src_s1[0]   <= cmd.src_channel0;
			src_s1[1]   <= cmd.src_channel1;
			src_s1[2]   <= cmd.src_channel2;
			fwd_data_s1 <= new_px;
		end
	end

	// old pixel, newest write wins
	assign old_px = fwd_hit_s1 ? fwd_data_s1 : rd_data;

	// per-channel copy or tint
	for (genvar k = 0; k < 3; k++) begin : g_chan
		assign old_ch[k] = old_px[8*k +: 8];
		mbb_tint u_tint (
			.d(old_ch[k]),
			.c(src_s1[k]),
			.v(tint_ch[k])
		);
		assign new_ch[k] = cfg_q.blend_mode ? tint_ch[k] : src_s1[k];
	end

	assign new_px = {new_ch[2], new_ch[1], new_ch[0]};

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			res_q.did_write  <= write_s1;
			res_q.skip_cause <= cause_s1;
			if (write_s1) begin
				res_q.out_channel0 <= new_ch[0];
				res_q.out_channel1 <= new_ch[1];
				res_q.out_channel2 <= new_ch[2];
			end else if (read_s1) begin
				res_q.out_channel0 <= old_ch[0];
				res_q.out_channel1 <= old_ch[1];
				res_q.out_channel2 <= old_ch[2];
			end else begin
				res_q.out_channel0 <= '0;
				res_q.out_channel1 <= '0;
				res_q.out_channel2 <= '0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a written pixel never carries a skip cause
	a_write_no_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.did_write |-> res.skip_cause == mbb_pkg::SKIP_NONE)
		else $error("written pixel reported with a skip cause");

	// no pixel write lands during the clearing pass
	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !item_we)
		else $error("pixel write during frame clearing");

	// a word leaving the blend stage shows up as a result
	a_stage_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && s1_adv |=> res_valid_q)
		else $error("blend stage word lost before the result register");

endmodule

`default_nettype wire
